### rtl/acl_pkg.sv
// Shared types, request codes and the prefix mask function for the IPv4 ACL core.
`default_nettype none
package acl_pkg;

  localparam int ADDR_W = 32;
  localparam int PLEN_W = 6;
  localparam int IDX_W  = 4;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;
  localparam logic [PLEN_W-1:0] ADDR_BITS = PLEN_W'(ADDR_W);

  typedef enum logic [1:0] {
    REQ_CHECK  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  // one beat travelling down the rule chain
  typedef struct packed {
    logic              vld;
    req_e              req;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic              deny;
    logic              verdict;
    logic              matched;
    logic [IDX_W-1:0]  idx;
    logic              status;
  } token_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    logic [PLEN_W-1:0] p;
    logic [ADDR_W-1:0] m;
    p = (plen > ADDR_BITS) ? ADDR_BITS : plen;
    if (p == '0) begin
      m = '0;
    end else begin
      m = ALL_ONES << (ADDR_BITS - p);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### rtl/acl_cell.sv
// One rule slot: stores a prefix rule and updates the passing beat.
`default_nettype none
module acl_cell
  import acl_pkg::*;
#(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire token_t        tok_in,
  input  wire logic [CW-1:0] cnt_in,
  output token_t             tok_out,
  output logic    [CW-1:0]   cnt_out
);

  localparam logic [CW-1:0] SLOT = CW'(IDX);

  logic [ADDR_W-1:0] net;
  logic [ADDR_W-1:0] mask;
  logic              deny;
  token_t            tok_next;
  logic              hit;

  assign hit = (cnt_in > SLOT) && ((tok_in.addr & mask) == net);

  always_comb begin
    tok_next = tok_in;
    if (tok_in.vld && tok_in.req == REQ_CHECK && hit) begin
      tok_next.matched = 1'b1;
      tok_next.verdict = deny;
      tok_next.idx     = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.vld && tok_in.req == REQ_APPEND && cnt_in == SLOT) begin
      net  <= tok_in.addr & tok_in.mask;
      mask <= tok_in.mask;
      deny <= tok_in.deny;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_next.vld;
    end
    tok_out.req     <= tok_next.req;
    tok_out.addr    <= tok_next.addr;
    tok_out.mask    <= tok_next.mask;
    tok_out.deny    <= tok_next.deny;
    tok_out.verdict <= tok_next.verdict;
    tok_out.matched <= tok_next.matched;
    tok_out.idx     <= tok_next.idx;
    tok_out.status  <= tok_next.status;
    cnt_out         <= cnt_in;
  end

endmodule
`default_nettype wire

### rtl/ipv4_acl_first_match_core.sv
// Top level: IPv4 first-match ACL as a chain of rule cells.
// A request beat is registered at the entry, then in each rule cell, and its result is registered at the chain end.
// Flow: one request in flight; the next beat is taken the cycle after the result
// is taken, so the rate is set by the walk down the cell chain and by the receiver.
// Reset: clears the rule count (table empty) and all valid flags; rule slots keep
// whatever they hold and are only read below the rule count.
`default_nettype none
module ipv4_acl_first_match_core
  import acl_pkg::*;
#(
  parameter int MAX_RULES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        req_type,
  input  wire logic [ADDR_W-1:0] ip_addr,
  input  wire logic [PLEN_W-1:0] prefix_len,
  input  wire logic              deny_rule,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   verdict,
  output logic                   matched,
  output logic [IDX_W-1:0]       match_index,
  output logic                   status
);

  localparam int CW = $clog2(MAX_RULES + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_RULES);

  logic          busy;
  logic [CW-1:0] rule_count;
  logic [CW-1:0] rule_count_next;
  logic          accept;
  token_t        entry_tok;
  token_t        entry_next;
  logic [CW-1:0] entry_cnt;
  token_t        res;

  token_t        tok_chain [MAX_RULES+1];
  logic [CW-1:0] cnt_chain [MAX_RULES+1];
  logic [MAX_RULES:0] vld_vec;

  assign in_stall = busy || out_valid;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    entry_next         = '0;
    entry_next.vld     = accept;
    entry_next.addr    = ip_addr;
    entry_next.mask    = prefix_mask(prefix_len);
    entry_next.deny    = deny_rule;
    rule_count_next    = rule_count;
    unique case (req_type)
      REQ_CHECK: begin
        entry_next.req     = REQ_CHECK;
        entry_next.verdict = (rule_count != '0);
      end
      REQ_APPEND: begin
        entry_next.req    = REQ_APPEND;
        entry_next.status = (rule_count == FULL);
        if (accept && rule_count != FULL) begin
          rule_count_next = rule_count + CW'(1);
        end
      end
      REQ_CLEAR: begin
        entry_next.req = REQ_CLEAR;
        if (accept) begin
          rule_count_next = '0;
        end
      end
      default: begin
        entry_next.vld = 1'b0;
        entry_next.req = REQ_CLEAR;
      end
    endcase
  end

  // unused request code still yields an all-zero result, so track it separately
  logic noop_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      rule_count <= '0;
      entry_tok.vld <= 1'b0;
      noop_pend  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rule_count    <= rule_count_next;
      entry_tok.vld <= entry_next.vld;
      noop_pend     <= accept && !entry_next.vld;
      if (accept) begin
        busy <= 1'b1;
      end else if (tok_chain[MAX_RULES].vld || noop_pend) begin
        busy <= 1'b0;
      end
      if (tok_chain[MAX_RULES].vld || noop_pend) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    entry_tok.req     <= entry_next.req;
    entry_tok.addr    <= entry_next.addr;
    entry_tok.mask    <= entry_next.mask;
    entry_tok.deny    <= entry_next.deny;
    entry_tok.verdict <= entry_next.verdict;
    entry_tok.matched <= entry_next.matched;
    entry_tok.idx     <= entry_next.idx;
    entry_tok.status  <= entry_next.status;
    entry_cnt         <= rule_count;
    if (noop_pend) begin
      res <= '0;
    end else if (tok_chain[MAX_RULES].vld) begin
      res <= tok_chain[MAX_RULES];
    end
  end

  assign tok_chain[0] = entry_tok;
  assign cnt_chain[0] = entry_cnt;

  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    acl_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok_chain[i]),
      .cnt_in  (cnt_chain[i]),
      .tok_out (tok_chain[i+1]),
      .cnt_out (cnt_chain[i+1])
    );
  end

  for (genvar i = 0; i <= MAX_RULES; i++) begin : g_vld
    assign vld_vec[i] = tok_chain[i].vld;
  end

  assign verdict     = res.verdict;
  assign matched     = res.matched;
  assign match_index = res.idx;
  assign status      = res.status;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0({vld_vec, noop_pend}))
    else $error("more than one beat in the rule chain");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rule_count <= FULL)
    else $error("rule count above table size");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_CLEAR) |=> (rule_count == '0))
    else $error("clear did not empty the table");

  a_result_from_chain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(tok_chain[MAX_RULES].vld || noop_pend))
    else $error("result without a beat leaving the chain");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && !accept))
    else $error("new beat taken while one is in flight");

endmodule
`default_nettype wire

### tb/sv/ipv4_acl_first_match_checker.sv
// Checker for the IPv4 first-match ACL core: predicts each result and compares it.
module ipv4_acl_first_match_checker
  import acl_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [ADDR_W-1:0] ip_addr,
  input  logic [PLEN_W-1:0] prefix_len,
  input  logic              deny_rule,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              verdict,
  input  logic              matched,
  input  logic [IDX_W-1:0]  match_index,
  input  logic              status,
  output int                failures,
  output int                pending,
  output int                checks_seen,
  output int                hits_seen,
  output int                refusals_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             verdict;
    logic             matched;
    logic [IDX_W-1:0] idx;
    logic             status;
  } acl_result_t;

  logic [ADDR_W-1:0] rule_net  [TABLE_DEPTH];
  logic [ADDR_W-1:0] rule_mask [TABLE_DEPTH];
  logic              rule_deny [TABLE_DEPTH];
  int                rule_count;
  acl_result_t       expected_results[$];
  int                result_no;

  initial begin
    failures      = 0;
    pending       = 0;
    checks_seen   = 0;
    hits_seen     = 0;
    refusals_seen = 0;
    rule_count    = 0;
    result_no     = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    failures++;
  endtask

  // updates the rule table and returns the result the request should produce
  function automatic acl_result_t judge_request(input logic [1:0] req,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [PLEN_W-1:0] plen,
                                                input logic deny);
    acl_result_t r;
    logic [ADDR_W-1:0] m;
    r = '0;
    case (req)
      REQ_CHECK: begin
        checks_seen++;
        if (rule_count > 0) begin
          r.verdict = 1'b1;
          for (int i = rule_count - 1; i >= 0; i--) begin
            if ((addr & rule_mask[i]) == rule_net[i]) begin
              r.verdict = rule_deny[i];
              r.matched = 1'b1;
              r.idx     = i[IDX_W-1:0];
              hits_seen++;
              break;
            end
          end
        end
      end
      REQ_APPEND: begin
        if (rule_count < TABLE_DEPTH) begin
          // lengths of 32 and above shift out every bit: host mask
          m = ~(32'hffff_ffff >> plen);
          rule_mask[rule_count] = m;
          rule_net[rule_count]  = addr & m;
          rule_deny[rule_count] = deny;
          rule_count++;
        end else begin
          r.status = 1'b1;
          refusals_seen++;
        end
      end
      REQ_CLEAR: rule_count = 0;
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    acl_result_t want;
    if (rst) begin
      rule_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        result_no++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_no));
        end else begin
          want = expected_results.pop_front();
          if (verdict !== want.verdict)
            report_mismatch($sformatf("result %0d verdict %b, expected %b",
                                      result_no, verdict, want.verdict));
          if (matched !== want.matched)
            report_mismatch($sformatf("result %0d matched %b, expected %b",
                                      result_no, matched, want.matched));
          if (match_index !== want.idx)
            report_mismatch($sformatf("result %0d match_index %0d, expected %0d",
                                      result_no, match_index, want.idx));
          if (status !== want.status)
            report_mismatch($sformatf("result %0d status %b, expected %b",
                                      result_no, status, want.status));
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(judge_request(req_type, ip_addr, prefix_len, deny_rule));
    end
    pending <= expected_results.size();
  end

endmodule

### tb/sv/ipv4_acl_first_match_core_tb.sv
// Testbench top for the IPv4 first-match ACL core: clock, reset, stimulus and verdict.
module ipv4_acl_first_match_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acl_pkg::*;

  localparam int         TABLE_DEPTH = 16;
  localparam int         ITEM_TARGET = 1950;
  localparam int         LONG_HOLD   = 400;
  localparam int         IDLE_LIMIT  = 3000;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        req_type;
  logic [ADDR_W-1:0] ip_addr;
  logic [PLEN_W-1:0] prefix_len;
  logic              deny_rule;
  logic              out_valid;
  logic              out_stall;
  logic              verdict;
  logic              matched;
  logic [IDX_W-1:0]  match_index;
  logic              status;

  int failures;
  int pending;
  int checks_seen;
  int hits_seen;
  int refusals_seen;

  int                sent;
  int                ignored;
  logic              burst;
  logic [ADDR_W-1:0] live_addr[$];
  logic [PLEN_W-1:0] live_plen[$];

  ipv4_acl_first_match_core #(.MAX_RULES(TABLE_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .ip_addr(ip_addr), .prefix_len(prefix_len), .deny_rule(deny_rule),
    .out_valid(out_valid), .out_stall(out_stall),
    .verdict(verdict), .matched(matched), .match_index(match_index), .status(status)
  );

  ipv4_acl_first_match_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .ip_addr(ip_addr), .prefix_len(prefix_len), .deny_rule(deny_rule),
    .out_valid(out_valid), .out_stall(out_stall),
    .verdict(verdict), .matched(matched), .match_index(match_index), .status(status),
    .failures(failures), .pending(pending), .checks_seen(checks_seen),
    .hits_seen(hits_seen), .refusals_seen(refusals_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  task automatic offer(input logic [1:0] req, input logic [ADDR_W-1:0] addr,
                       input logic [PLEN_W-1:0] plen, input logic deny);
    int gap;
    @(negedge clk);
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    ip_addr    <= addr;
    prefix_len <= plen;
    deny_rule  <= deny;
    do @(posedge clk); while (in_stall);
    if (req == REQ_UNUSED) begin
      ignored++;
    end else begin
      sent++;
    end
    if (req == REQ_APPEND && live_addr.size() < TABLE_DEPTH) begin
      live_addr.push_back(addr);
      live_plen.push_back(plen);
    end
    if (req == REQ_CLEAR) begin
      live_addr.delete();
      live_plen.delete();
    end
  endtask

  function automatic logic [PLEN_W-1:0] pick_plen();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 10) return PLEN_W'($urandom_range(33, 63));
    return PLEN_W'($urandom_range(1, 32));
  endfunction

  // address near an existing rule: same network, random host bits, sometimes one bit off
  function automatic logic [ADDR_W-1:0] near_rule();
    int k;
    logic [ADDR_W-1:0] a;
    k = $urandom_range(0, live_addr.size() - 1);
    a = live_addr[k] ^ ($urandom & (32'hffff_ffff >> live_plen[k]));
    if ($urandom_range(0, 4) == 0) a = a ^ (32'h1 << $urandom_range(0, 31));
    return a;
  endfunction

  // receiver
  initial begin
    int chunk;
    int stall;
    chunk = 0;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      chunk++;
      if (chunk == 5 || chunk == 60) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 150)) @(negedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_stall <= 1'b1;
          repeat (stall) @(negedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
  end

  // watchdog
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("watchdog: %0d cycles without a beat, %0d results outstanding", idle, pending);
    $display("ipv4_acl_first_match_core_tb failed");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] last_host;
    logic [ADDR_W-1:0] a;
    int n_app;
    int n_chk;
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = REQ_CHECK;
    ip_addr    = '0;
    prefix_len = '0;
    deny_rule  = 1'b0;
    sent       = 0;
    ignored    = 0;
    burst      = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, unused code, saturation, prefix zero, newest first, full
    offer(REQ_CHECK,  32'hffff_ffff, '0, 1'b0);
    offer(REQ_UNUSED, 32'hffff_ffff, '1, 1'b1);
    offer(REQ_APPEND, 32'hc0a8_014d, 6'd24, 1'b1);
    offer(REQ_APPEND, 32'hffff_ffff, 6'd40, 1'b0);
    offer(REQ_CHECK,  32'hc0a8_0105, '0, 1'b0);
    offer(REQ_CHECK,  32'hffff_ffff, '0, 1'b0);
    offer(REQ_CHECK,  32'h0a00_0001, '0, 1'b0);
    offer(REQ_APPEND, 32'hdead_beef, 6'd0, 1'b1);
    offer(REQ_CHECK,  32'h1234_5678, '0, 1'b0);
    offer(REQ_CHECK,  32'hc0a8_0105, '0, 1'b0);
    last_host = '0;
    repeat (TABLE_DEPTH - 3) begin
      last_host = $urandom;
      offer(REQ_APPEND, last_host, 6'd32, 1'($urandom_range(0, 1)));
    end
    offer(REQ_APPEND, $urandom, 6'd32, 1'b1);
    offer(REQ_CHECK,  last_host, '0, 1'b0);
    offer(REQ_CLEAR,  '1, '1, 1'b1);
    offer(REQ_CHECK,  '0, '0, 1'b0);

    // random: rule sets of random content, checks aimed mostly at them
    while (sent < ITEM_TARGET) begin
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) offer(REQ_CLEAR, $urandom, PLEN_W'($urandom), 1'($urandom));
      n_app = ($urandom_range(0, 9) < 2) ? $urandom_range(12, 20) : $urandom_range(0, 5);
      repeat (n_app) begin
        a = (live_addr.size() > 0 && $urandom_range(0, 2) == 0) ? near_rule() : $urandom;
        offer(REQ_APPEND, a, pick_plen(), 1'($urandom_range(0, 1)));
      end
      n_chk = $urandom_range(1, 12);
      repeat (n_chk) begin
        case ($urandom_range(0, 19))
          0:       a = '0;
          1:       a = '1;
          2, 3, 4: a = $urandom;
          default: a = (live_addr.size() > 0) ? near_rule() : $urandom;
        endcase
        offer(REQ_CHECK, a, PLEN_W'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 14) == 0) offer(REQ_UNUSED, $urandom, PLEN_W'($urandom), 1'($urandom));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 4) @(posedge clk);

    $display("run: %0d requests plus %0d with the unused code; %0d checks, %0d hit a rule",
             sent, ignored, checks_seen, hits_seen);
    $display("run: %0d appends refused on a full table, %0d mismatches", refusals_seen, failures);
    if (failures == 0 && pending == 0) begin
      $display("ipv4_acl_first_match_core_tb passed");
    end else begin
      $display("ipv4_acl_first_match_core_tb failed");
    end
    $finish;
  end

endmodule

### ipv4_acl_first_match_core.f
rtl/acl_pkg.sv
rtl/acl_cell.sv
rtl/ipv4_acl_first_match_core.sv
tb/sv/ipv4_acl_first_match_checker.sv
tb/sv/ipv4_acl_first_match_core_tb.sv
